// ----- rtl/core/ppdm_pkg.sv -----
// types, constants and helpers shared by the position pd loop blocks
// no dependencies
package ppdm_pkg;

	localparam logic signed [31:0] S32_LOW  = 32'sh8000_0000;
	localparam logic signed [31:0] S32_HIGH = 32'sh7FFF_FFFF;

	// configuration register indexes
	localparam logic [2:0] REG_POSITION_GAIN        = 3'd0;
	localparam logic [2:0] REG_DAMPING_GAIN         = 3'd1;
	localparam logic [2:0] REG_TRACKING_SPEED_LIMIT = 3'd2;
	localparam logic [2:0] REG_SETTLE_TOLERANCE     = 3'd3;
	localparam logic [2:0] REG_SETTLE_SPEED_LIMIT   = 3'd4;
	localparam logic [2:0] REG_SETTLE_TICKS         = 3'd5;
	localparam logic [2:0] REG_ERROR_MARGIN         = 3'd6;
	localparam logic [2:0] REG_ERROR_TIMEOUT_TICKS  = 3'd7;

	// fault codes
	localparam logic [1:0] FAULT_NONE       = 2'd0;
	localparam logic [1:0] FAULT_SPEED_LOOP = 2'd1;
	localparam logic [1:0] FAULT_POS_ERROR  = 2'd2;

	// divide by 1000 through two exact reciprocal multiplies
	localparam int          DIV_DEN = 1000;
	localparam logic [31:0] DIV_R1  = 32'd2199023256;  // ceil(2^41 / 1000)
	localparam int          DIV_K1  = 41;
	localparam logic [26:0] DIV_R2  = 27'd68719477;    // ceil(2^36 / 1000)
	localparam int          DIV_K2  = 36;

	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] position_gain;
		logic [15:0] damping_gain;
		logic [30:0] tracking_speed_limit;
		logic [30:0] settle_tolerance;
		logic [30:0] settle_speed_limit;
		logic [15:0] settle_ticks;
		logic [30:0] error_margin;
		logic [15:0] error_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] measured_position;
		logic signed [31:0] measured_speed;
		logic signed [31:0] reference_position;
		logic signed [31:0] reference_speed;
		logic signed [31:0] target_position;
		logic               external_mode;
		logic               trajectory_done;
		logic               new_command;
		logic               speed_loop_ok;
	} in_item_t;

	// front end results, third stage
	typedef struct packed {
		logic signed [31:0] err;
		logic [30:0]        abs_err;
		logic [30:0]        abs_ferr;
		logic [30:0]        abs_speed;
		logic signed [48:0] p;
		logic [46:0]        dm;
		logic               neg;
		logic signed [31:0] ref_speed;
		logic               ext;
		logic               done;
		logic               newcmd;
		logic               spdok;
	} front_t;

	typedef struct packed {
		logic       run;
		logic       reached;
		logic [1:0] fault;
	} mon_stat_t;

	// side information that travels with a beat through the command stages
	typedef struct packed {
		logic signed [31:0] err;
		logic signed [48:0] p;
		logic               neg;
		logic signed [31:0] ref_speed;
		logic               ext;
		mon_stat_t          stat;
	} tag_t;

	function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			return d[32] ? S32_LOW : S32_HIGH;
		end
		return d[31:0];
	endfunction

	// most negative value maps to the largest positive one
	function automatic logic [30:0] abs32(input logic signed [31:0] v);
		logic [31:0] n;
		n = -v;
		if (v == S32_LOW) begin
			return 31'h7FFF_FFFF;
		end
		return v[31] ? n[30:0] : v[30:0];
	endfunction

endpackage

// ----- rtl/core/ppdm_cfg_regs.sv -----
// configuration register file for the position pd loop
// depends on ppdm_pkg
module ppdm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [2:0]    cfg_index,
	input  logic [30:0]   cfg_data,
	output ppdm_pkg::cfg_t cfg
);

	ppdm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_gain        <= 16'd1;
			cfg_q.damping_gain         <= 16'd0;
			cfg_q.tracking_speed_limit <= 31'd1;
			cfg_q.settle_tolerance     <= 31'd0;
			cfg_q.settle_speed_limit   <= 31'd0;
			cfg_q.settle_ticks         <= 16'd1;
			cfg_q.error_margin         <= 31'd1;
			cfg_q.error_timeout_ticks  <= 16'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ppdm_pkg::REG_POSITION_GAIN:        cfg_q.position_gain <= cfg_data[15:0];
				ppdm_pkg::REG_DAMPING_GAIN:         cfg_q.damping_gain <= cfg_data[15:0];
				ppdm_pkg::REG_TRACKING_SPEED_LIMIT: cfg_q.tracking_speed_limit <= cfg_data;
				ppdm_pkg::REG_SETTLE_TOLERANCE:     cfg_q.settle_tolerance <= cfg_data;
				ppdm_pkg::REG_SETTLE_SPEED_LIMIT:   cfg_q.settle_speed_limit <= cfg_data;
				ppdm_pkg::REG_SETTLE_TICKS:         cfg_q.settle_ticks <= cfg_data[15:0];
				ppdm_pkg::REG_ERROR_MARGIN:         cfg_q.error_margin <= cfg_data;
				ppdm_pkg::REG_ERROR_TIMEOUT_TICKS:  cfg_q.error_timeout_ticks <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/ppdm_front.sv -----
// front end: saturated errors, magnitudes and the two gain multiplies
// depends on ppdm_pkg; two stages behind the input register
module ppdm_front (
	input  logic               clk,
	input  logic               adv,
	input  ppdm_pkg::in_item_t item_s1,
	input  logic [15:0]        position_gain,
	input  logic [15:0]        damping_gain,
	output ppdm_pkg::front_t   front_s3
);

	logic signed [31:0] err_s2;
	logic signed [31:0] ferr_s2;
	logic signed [31:0] speed_s2;
	logic [31:0]        mag_s2;
	logic signed [31:0] ref_speed_s2;
	logic               ext_s2;
	logic               done_s2;
	logic               newcmd_s2;
	logic               spdok_s2;

	logic [31:0]        neg_speed;
	logic signed [48:0] p_full;
	logic [47:0]        dm_full;

	ppdm_pkg::front_t   front_q_s3;

	// true magnitude of the speed; the most negative value gives 2^31
	assign neg_speed = -item_s1.measured_speed;

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s2       <= ppdm_pkg::sat_diff(item_s1.reference_position,
				item_s1.measured_position);
			ferr_s2      <= ppdm_pkg::sat_diff(item_s1.target_position,
				item_s1.measured_position);
			speed_s2     <= item_s1.measured_speed;
			mag_s2       <= item_s1.measured_speed[31] ? neg_speed : item_s1.measured_speed;
			ref_speed_s2 <= item_s1.reference_speed;
			ext_s2       <= item_s1.external_mode;
			done_s2      <= item_s1.trajectory_done;
			newcmd_s2    <= item_s1.new_command;
			spdok_s2     <= item_s1.speed_loop_ok;
		end
	end

	assign p_full  = 49'($signed({1'b0, position_gain})) * 49'(err_s2);
	assign dm_full = {32'b0, damping_gain} * {16'b0, mag_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			front_q_s3.err       <= err_s2;
			front_q_s3.abs_err   <= ppdm_pkg::abs32(err_s2);
			front_q_s3.abs_ferr  <= ppdm_pkg::abs32(ferr_s2);
			front_q_s3.abs_speed <= ppdm_pkg::abs32(speed_s2);
			front_q_s3.p         <= p_full;
			front_q_s3.dm        <= dm_full[46:0];
			front_q_s3.neg       <= speed_s2[31];
			front_q_s3.ref_speed <= ref_speed_s2;
			front_q_s3.ext       <= ext_s2;
			front_q_s3.done      <= done_s2;
			front_q_s3.newcmd    <= newcmd_s2;
			front_q_s3.spdok     <= spdok_s2;
		end
	end

	assign front_s3 = front_q_s3;

endmodule

// ----- rtl/core/ppdm_monitor.sv -----
// loop state: run flag, fault, initial error, excess and settle counters
// depends on ppdm_pkg; updated once per beat as it leaves the third stage
module ppdm_monitor #(
	parameter int MONITOR_DIVIDE = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ppdm_pkg::front_t    front_s3,
	input  ppdm_pkg::cfg_t      cfg,
	output ppdm_pkg::mon_stat_t stat
);

	localparam int DW = (MONITOR_DIVIDE > 1) ? $clog2(MONITOR_DIVIDE) : 1;

	logic          run_q, run_n;
	logic [1:0]    fault_q, fault_n;
	logic [30:0]   init_err_q, init_err_n;
	logic [15:0]   excess_q, excess_n;
	logic [15:0]   settled_q, settled_n;
	logic          reached_q, reached_n;
	logic [DW-1:0] div_q, div_n;

	logic [DW:0]   div_inc;
	logic          mon_now;
	logic [31:0]   err_bound;
	logic          settle_ok;

	always_comb begin
		run_n      = run_q;
		fault_n    = fault_q;
		init_err_n = init_err_q;
		excess_n   = excess_q;
		settled_n  = settled_q;
		reached_n  = reached_q;
		div_n      = div_q;
		div_inc    = '0;
		mon_now    = 1'b0;
		err_bound  = '0;
		settle_ok  = 1'b0;

		if (front_s3.newcmd) begin
			init_err_n = front_s3.abs_ferr;
			fault_n    = ppdm_pkg::FAULT_NONE;
			excess_n   = '0;
			settled_n  = '0;
			reached_n  = 1'b0;
			div_n      = '0;
			run_n      = 1'b1;
		end

		if (run_n) begin
			if (!front_s3.spdok) begin
				fault_n = ppdm_pkg::FAULT_SPEED_LOOP;
				run_n   = 1'b0;
				div_n   = '0;
			end else begin
				div_inc = {1'b0, div_n} + {{DW{1'b0}}, 1'b1};
				mon_now = !front_s3.ext || (div_inc >= (DW+1)'(MONITOR_DIVIDE));
				if (front_s3.ext) begin
					div_n = mon_now ? '0 : div_inc[DW-1:0];
				end
				if (mon_now) begin
					err_bound = {1'b0, init_err_n} + {1'b0, cfg.error_margin};
					if ({1'b0, front_s3.abs_err} > err_bound) begin
						if (excess_n != ppdm_pkg::CNT_MAX) begin
							excess_n = excess_n + 16'd1;
						end
						if (excess_n >= cfg.error_timeout_ticks) begin
							fault_n = ppdm_pkg::FAULT_POS_ERROR;
							run_n   = 1'b0;
							div_n   = '0;
						end
					end else begin
						excess_n = '0;
					end
					// the settle check runs even on a timeout tick
					settle_ok = (front_s3.ext || front_s3.done) &&
						(front_s3.abs_ferr <= cfg.settle_tolerance) &&
						(front_s3.abs_speed <= cfg.settle_speed_limit);
					if (settle_ok) begin
						if (settled_n != ppdm_pkg::CNT_MAX) begin
							settled_n = settled_n + 16'd1;
						end
						reached_n = (settled_n >= cfg.settle_ticks);
					end else begin
						settled_n = '0;
						reached_n = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			fault_q    <= ppdm_pkg::FAULT_NONE;
			init_err_q <= '0;
			excess_q   <= '0;
			settled_q  <= '0;
			reached_q  <= 1'b0;
			div_q      <= '0;
		end else if (en) begin
			run_q      <= run_n;
			fault_q    <= fault_n;
			init_err_q <= init_err_n;
			excess_q   <= excess_n;
			settled_q  <= settled_n;
			reached_q  <= reached_n;
			div_q      <= div_n;
		end
	end

	assign stat.run     = run_n;
	assign stat.reached = reached_n;
	assign stat.fault   = fault_n;

endmodule

// ----- rtl/core/ppdm_damp_div.sv -----
// damping term magnitude divided by 1000, truncated
// depends on ppdm_pkg; split as (hi*2^16 + lo) with two exact reciprocal multiplies
module ppdm_damp_div (
	input  logic        clk,
	input  logic        adv,
	input  logic [46:0] dm_s3,
	output logic [37:0] q_s6
);

	logic [30:0] a;
	logic [62:0] prod1;

	logic [62:0] prod1_s4;
	logic [30:0] a_s4;
	logic [15:0] b_s4;

	logic [21:0] qa;
	logic [30:0] qa_x;
	logic [30:0] ra_full;
	logic [25:0] t;

	logic [21:0] qa_s5;
	logic [25:0] t_s5;

	logic [52:0] prod2;
	logic [52:0] prod2_s6;
	logic [21:0] qa_s6;

	assign a     = dm_s3[46:16];
	assign prod1 = 63'(a) * 63'(ppdm_pkg::DIV_R1);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod1_s4 <= prod1;
			a_s4     <= a;
			b_s4     <= dm_s3[15:0];
		end
	end

	// quotient of the high part, and its remainder carried into the low part
	assign qa      = prod1_s4[62:ppdm_pkg::DIV_K1];
	assign qa_x    = 31'(qa) * 31'(ppdm_pkg::DIV_DEN);
	assign ra_full = a_s4 - qa_x;
	assign t       = {ra_full[9:0], b_s4};

	always_ff @(posedge clk) begin
		if (adv) begin
			qa_s5 <= qa;
			t_s5  <= t;
		end
	end

	assign prod2 = 53'(t_s5) * 53'(ppdm_pkg::DIV_R2);

	always_ff @(posedge clk) begin
		if (adv) begin
			prod2_s6 <= prod2;
			qa_s6    <= qa_s5;
		end
	end

	// low quotient stays below 2^16, so the two parts simply concatenate
	assign q_s6 = {qa_s6, prod2_s6[ppdm_pkg::DIV_K2+15:ppdm_pkg::DIV_K2]};

endmodule

// ----- rtl/core/ppdm_cmd.sv -----
// speed command: pd sum, external-mode sign block, feedforward and clamp
// depends on ppdm_pkg; inputs arrive from the sixth, seventh and eighth stages
module ppdm_cmd (
	input  logic               clk,
	input  logic               adv,
	input  ppdm_pkg::tag_t     tag_s6,
	input  logic [37:0]        q_s6,
	input  ppdm_pkg::tag_t     tag_s7,
	input  ppdm_pkg::tag_t     tag_s8,
	input  logic [30:0]        limit,
	output logic signed [31:0] speed_command
);

	logic signed [48:0] q_ext;
	logic signed [48:0] cmd0;
	logic signed [48:0] cmd0_s7;

	logic               err_pos;
	logic               err_neg;
	logic               cmd_pos;
	logic               cmd_neg;
	logic signed [49:0] cmd1;
	logic signed [49:0] cmd1_s8;

	logic signed [49:0] lim_pos;
	logic signed [49:0] lim_neg;
	logic signed [49:0] clamped;

	assign q_ext = $signed({11'b0, q_s6});
	// subtracting the signed damping term is an add or subtract of its magnitude
	assign cmd0  = tag_s6.neg ? (tag_s6.p + q_ext) : (tag_s6.p - q_ext);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd0_s7 <= cmd0;
		end
	end

	assign err_pos = !tag_s7.err[31] && (tag_s7.err != 32'sd0);
	assign err_neg = tag_s7.err[31];
	assign cmd_pos = !cmd0_s7[48] && (cmd0_s7 != 49'sd0);
	assign cmd_neg = cmd0_s7[48];

	always_comb begin
		if (tag_s7.ext) begin
			if ((err_pos && cmd_neg) || (err_neg && cmd_pos)) begin
				cmd1 = '0;
			end else begin
				cmd1 = 50'(cmd0_s7);
			end
		end else begin
			cmd1 = 50'(cmd0_s7) + 50'(tag_s7.ref_speed);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd1_s8 <= cmd1;
		end
	end

	assign lim_pos = $signed({19'b0, limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (cmd1_s8 > lim_pos) begin
			clamped = lim_pos;
		end else if (cmd1_s8 < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = cmd1_s8;
		end
	end

	assign speed_command = tag_s8.stat.run ? clamped[31:0] : 32'sd0;

endmodule

// ----- rtl/core/position_pd_loop_with_monitor.sv -----
// top level of the position pd loop with error and settle monitor
// depends on ppdm_pkg, ppdm_cfg_regs, ppdm_front, ppdm_monitor, ppdm_damp_div, ppdm_cmd
//
// One control tick is taken per clock cycle while in_stall is low, and its result beat
// passes through nine register stages: an input register, two front stages for the
// saturated errors and the gain multiplies, three stages for the divide by 1000 of the
// damping term (two reciprocal multiplies), and three stages that sum, sign-block, add
// feedforward and clamp, the last being the output register. Loop state (run, fault,
// counters, initial error) updates as each beat leaves the third stage, so ticks follow
// each other back to back. A stall on the result side while a beat waits at the output
// freezes the whole pipeline and is passed straight back as in_stall; configuration
// should be written only while no beat is in flight.
module position_pd_loop_with_monitor #(
	parameter int MONITOR_DIVIDE = 4
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] measured_position,
	input  logic signed [31:0] measured_speed,
	input  logic signed [31:0] reference_position,
	input  logic signed [31:0] reference_speed,
	input  logic signed [31:0] target_position,
	input  logic               external_mode,
	input  logic               trajectory_done,
	input  logic               new_command,
	input  logic               speed_loop_ok,

	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] speed_command,
	output logic signed [31:0] position_error,
	output logic               reached,
	output logic               running,
	output logic [1:0]         fault_code,

	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data
);

	ppdm_pkg::cfg_t      cfg;
	ppdm_pkg::in_item_t  item_s1;
	ppdm_pkg::front_t    front_s3;
	ppdm_pkg::mon_stat_t stat;
	ppdm_pkg::tag_t      tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [37:0]         q_s6;
	logic signed [31:0]  cmd;

	// one valid bit per stage: bits 0..7 are stages one to eight, bit 8 the output
	logic [8:0]          vld_q;
	logic                adv;

	logic signed [31:0]  speed_command_q;
	logic signed [31:0]  position_error_q;
	logic                reached_q;
	logic                running_q;
	logic [1:0]          fault_code_q;

	assign in_stall = vld_q[8] && out_stall;
	assign adv      = !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[7:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.measured_position  <= measured_position;
			item_s1.measured_speed     <= measured_speed;
			item_s1.reference_position <= reference_position;
			item_s1.reference_speed    <= reference_speed;
			item_s1.target_position    <= target_position;
			item_s1.external_mode      <= external_mode;
			item_s1.trajectory_done    <= trajectory_done;
			item_s1.new_command        <= new_command;
			item_s1.speed_loop_ok      <= speed_loop_ok;
		end
	end

	ppdm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppdm_front u_front (
		.clk           (clk),
		.adv           (adv),
		.item_s1       (item_s1),
		.position_gain (cfg.position_gain),
		.damping_gain  (cfg.damping_gain),
		.front_s3      (front_s3)
	);

	ppdm_monitor #(
		.MONITOR_DIVIDE (MONITOR_DIVIDE)
	) u_monitor (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv && vld_q[2]),
		.front_s3 (front_s3),
		.cfg      (cfg),
		.stat     (stat)
	);

	ppdm_damp_div u_div (
		.clk   (clk),
		.adv   (adv),
		.dm_s3 (front_s3.dm),
		.q_s6  (q_s6)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4.err       <= front_s3.err;
			tag_s4.p         <= front_s3.p;
			tag_s4.neg       <= front_s3.neg;
			tag_s4.ref_speed <= front_s3.ref_speed;
			tag_s4.ext       <= front_s3.ext;
			tag_s4.stat      <= stat;
			tag_s5           <= tag_s4;
			tag_s6           <= tag_s5;
			tag_s7           <= tag_s6;
			tag_s8           <= tag_s7;
		end
	end

	ppdm_cmd u_cmd (
		.clk           (clk),
		.adv           (adv),
		.tag_s6        (tag_s6),
		.q_s6          (q_s6),
		.tag_s7        (tag_s7),
		.tag_s8        (tag_s8),
		.limit         (cfg.tracking_speed_limit),
		.speed_command (cmd)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			speed_command_q  <= cmd;
			position_error_q <= tag_s8.err;
			reached_q        <= tag_s8.stat.reached;
			running_q        <= tag_s8.stat.run;
			fault_code_q     <= tag_s8.stat.fault;
		end
	end

	assign out_valid      = vld_q[8];
	assign speed_command  = speed_command_q;
	assign position_error = position_error_q;
	assign reached        = reached_q;
	assign running        = running_q;
	assign fault_code     = fault_code_q;

	// a running loop never reports a fault
	a_run_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running |-> fault_code == ppdm_pkg::FAULT_NONE)
		else $error("running beat carries a fault code");

	// a stopped loop commands zero speed
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> speed_command == 32'sd0)
		else $error("non-zero speed command while stopped");

	// command stays inside the tracking clamp
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (speed_command <= $signed({1'b0, cfg.tracking_speed_limit})) &&
			(speed_command >= -$signed({1'b0, cfg.tracking_speed_limit})))
		else $error("speed command outside tracking limit");

	// fault code zero, one or two only, never the unused code
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fault_code == ppdm_pkg::FAULT_NONE ||
			fault_code == ppdm_pkg::FAULT_SPEED_LOOP ||
			fault_code == ppdm_pkg::FAULT_POS_ERROR)
		else $error("undefined fault code");

endmodule

// ----- test/ppdm_tick_checker.sv -----
`timescale 1ns / 1ps
// result checker for position_pd_loop_with_monitor: mirrors register writes, predicts every
// accepted control tick and compares the result beats in order; depends on ppdm_pkg
module ppdm_tick_checker #(
	parameter int MONITOR_DIVIDE = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] measured_position,
	input  logic signed [31:0] measured_speed,
	input  logic signed [31:0] reference_position,
	input  logic signed [31:0] reference_speed,
	input  logic signed [31:0] target_position,
	input  logic               external_mode,
	input  logic               trajectory_done,
	input  logic               new_command,
	input  logic               speed_loop_ok,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] speed_command,
	input  logic signed [31:0] position_error,
	input  logic               reached,
	input  logic               running,
	input  logic [1:0]         fault_code,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	output int                 mismatches,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] speed_command;
		logic signed [31:0] position_error;
		logic               reached;
		logic               running;
		logic [1:0]         fault_code;
	} tick_result_t;

	tick_result_t       expected_results[$];
	tick_result_t       got, want;
	ppdm_pkg::in_item_t item;

	// register copies
	longint kp, kd, cmd_limit, settle_tol, settle_spd, settle_need, err_margin, timeout_need;

	// loop state
	bit         loop_on, reached_q;
	logic [1:0] fault_q;
	longint     init_err;
	int         excess_cnt, settle_cnt, div_cnt;

	function automatic longint clip32(input longint v);
		if (v > ppdm_pkg::S32_HIGH) return ppdm_pkg::S32_HIGH;
		if (v < ppdm_pkg::S32_LOW) return ppdm_pkg::S32_LOW;
		return v;
	endfunction

	function automatic longint magnitude(input longint v);
		if (v <= ppdm_pkg::S32_LOW) return ppdm_pkg::S32_HIGH;
		return (v < 0) ? -v : v;
	endfunction

	function automatic void update_monitor(input longint err, input longint ferr,
			input longint spd, input bit ext, input bit done);
		if (magnitude(err) > init_err + err_margin) begin
			if (excess_cnt < ppdm_pkg::CNT_MAX) excess_cnt++;
			if (excess_cnt >= timeout_need) begin
				fault_q = ppdm_pkg::FAULT_POS_ERROR;
				loop_on = 1'b0;
				div_cnt = 0;
			end
		end else begin
			excess_cnt = 0;
		end
		// settle check still runs on the tick that trips the error timeout
		if ((ext || done) && magnitude(ferr) <= settle_tol && magnitude(spd) <= settle_spd) begin
			if (settle_cnt < ppdm_pkg::CNT_MAX) settle_cnt++;
			reached_q = (settle_cnt >= settle_need);
		end else begin
			settle_cnt = 0;
			reached_q = 1'b0;
		end
	endfunction

	function automatic tick_result_t predict_tick(input ppdm_pkg::in_item_t t);
		longint       err, ferr, spd, cmd;
		tick_result_t r;
		err = clip32(longint'(t.reference_position) - longint'(t.measured_position));
		ferr = clip32(longint'(t.target_position) - longint'(t.measured_position));
		spd = t.measured_speed;
		cmd = 0;
		if (t.new_command) begin
			init_err = magnitude(ferr);
			fault_q = ppdm_pkg::FAULT_NONE;
			excess_cnt = 0;
			settle_cnt = 0;
			reached_q = 1'b0;
			div_cnt = 0;
			loop_on = 1'b1;
		end
		if (loop_on) begin
			if (!t.speed_loop_ok) begin
				fault_q = ppdm_pkg::FAULT_SPEED_LOOP;
				loop_on = 1'b0;
				div_cnt = 0;
			end else begin
				cmd = kp * err - (kd * spd) / ppdm_pkg::DIV_DEN;
				if (t.external_mode) begin
					// never push against the error in step mode
					if ((err > 0 && cmd < 0) || (err < 0 && cmd > 0)) cmd = 0;
				end else begin
					cmd += longint'(t.reference_speed);
				end
				if (cmd > cmd_limit) cmd = cmd_limit;
				if (cmd < -cmd_limit) cmd = -cmd_limit;
				if (t.external_mode) begin
					if (div_cnt + 1 >= MONITOR_DIVIDE) begin
						div_cnt = 0;
						update_monitor(err, ferr, spd, 1'b1, t.trajectory_done);
					end else begin
						div_cnt++;
					end
				end else begin
					update_monitor(err, ferr, spd, 1'b0, t.trajectory_done);
				end
			end
		end
		if (!loop_on) cmd = 0;
		r.speed_command = cmd[31:0];
		r.position_error = err[31:0];
		r.reached = reached_q;
		r.running = loop_on;
		r.fault_code = fault_q;
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = 1;
			kd = 0;
			cmd_limit = 1;
			settle_tol = 0;
			settle_spd = 0;
			settle_need = 1;
			err_margin = 1;
			timeout_need = 1;
			loop_on = 1'b0;
			reached_q = 1'b0;
			fault_q = ppdm_pkg::FAULT_NONE;
			init_err = 0;
			excess_cnt = 0;
			settle_cnt = 0;
			div_cnt = 0;
			expected_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					ppdm_pkg::REG_POSITION_GAIN:        kp = cfg_data[15:0];
					ppdm_pkg::REG_DAMPING_GAIN:         kd = cfg_data[15:0];
					ppdm_pkg::REG_TRACKING_SPEED_LIMIT: cmd_limit = cfg_data;
					ppdm_pkg::REG_SETTLE_TOLERANCE:     settle_tol = cfg_data;
					ppdm_pkg::REG_SETTLE_SPEED_LIMIT:   settle_spd = cfg_data;
					ppdm_pkg::REG_SETTLE_TICKS:         settle_need = cfg_data[15:0];
					ppdm_pkg::REG_ERROR_MARGIN:         err_margin = cfg_data;
					ppdm_pkg::REG_ERROR_TIMEOUT_TICKS:  timeout_need = cfg_data[15:0];
					default: ;
				endcase
			end
			// a result beat leaves only after its tick has passed every register stage, so check first
			if (out_valid && !out_stall) begin
				got = '{speed_command, position_error, reached, running, fault_code};
				if (expected_results.size() == 0) begin
					note_failure($sformatf("unexpected result beat at %0t: cmd %0d err %0d",
						$time, got.speed_command, got.position_error));
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						note_failure($sformatf({"result mismatch at %0t: expected cmd %0d ",
							"err %0d reached %0b running %0b fault %0d, got cmd %0d err %0d ",
							"reached %0b running %0b fault %0d"}, $time,
							want.speed_command, want.position_error, want.reached,
							want.running, want.fault_code, got.speed_command,
							got.position_error, got.reached, got.running, got.fault_code));
					end
				end
			end
			if (in_valid && !in_stall) begin
				item = '{measured_position, measured_speed, reference_position,
					reference_speed, target_position, external_mode, trajectory_done,
					new_command, speed_loop_ok};
				expected_results.push_back(predict_tick(item));
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- test/position_pd_loop_with_monitor_tb.sv -----
`timescale 1ns / 1ps
// testbench top for position_pd_loop_with_monitor: directed and random control ticks under
// several register settings, with bursty input and a stalling receiver; depends on
// ppdm_pkg, ppdm_tick_checker and the block itself
module position_pd_loop_with_monitor_tb;

	typedef enum int {
		SETUP_DIRECTED,
		SETUP_ZERO,
		SETUP_MAX,
		SETUP_MIN,
		SETUP_RANDOM
	} setup_e;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] measured_position = '0;
	logic signed [31:0] measured_speed = '0;
	logic signed [31:0] reference_position = '0;
	logic signed [31:0] reference_speed = '0;
	logic signed [31:0] target_position = '0;
	logic               external_mode = 1'b0;
	logic               trajectory_done = 1'b0;
	logic               new_command = 1'b0;
	logic               speed_loop_ok = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] speed_command;
	logic signed [31:0] position_error;
	logic               reached;
	logic               running;
	logic [1:0]         fault_code;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = ppdm_pkg::REG_POSITION_GAIN;
	logic [30:0]        cfg_data = '0;
	int                 mismatches;
	int                 pending;

	// sender burst state
	bit gaps_on;
	int burst_left;

	// current move sequence of the random part
	int seq_left, seq_target, seq_dist, seq_push;
	bit seq_ext, seq_runaway;

	always #5 clk = ~clk;

	position_pd_loop_with_monitor #(.MONITOR_DIVIDE(4)) DUT (.*);

	ppdm_tick_checker #(.MONITOR_DIVIDE(4)) u_checker (.*);

	function automatic ppdm_pkg::in_item_t make_tick(input int meas, input int spd,
			input int refp, input int rspd, input int tgt, input bit ext, input bit done,
			input bit newc, input bit ok);
		ppdm_pkg::in_item_t t;
		t = '{meas, spd, refp, rspd, tgt, ext, done, newc, ok};
		return t;
	endfunction

	function automatic ppdm_pkg::cfg_t pick_config(input setup_e kind);
		ppdm_pkg::cfg_t c;
		case (kind)
			SETUP_DIRECTED: c = '{3, 2000, 50000, 4, 100, 2, 20, 2};
			SETUP_ZERO:     c = '{5, 0, 0, 0, 0, 0, 0, 0};
			SETUP_MAX: c = '{16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
				31'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF};
			SETUP_MIN:      c = '{1, 0, 1, 0, 0, 1, 1, 1};
			default: begin
				c.position_gain = 16'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 300)
					: $urandom_range(1, 65535));
				c.damping_gain = 16'(($urandom_range(0, 3) == 0) ? 0
					: $urandom_range(0, 65535));
				c.tracking_speed_limit = 31'($urandom_range(0, 1)
					? $urandom_range(1, 32'h7FFF_FFFF) : $urandom_range(100, 200000));
				c.settle_tolerance = 31'($urandom_range(0, 30));
				c.settle_speed_limit = 31'($urandom_range(0, 300));
				c.settle_ticks = 16'($urandom_range(1, 6));
				c.error_margin = 31'(($urandom_range(0, 7) == 0)
					? $urandom_range(1, 32'h7FFF_FFFF) : $urandom_range(1, 60));
				c.error_timeout_ticks = 16'($urandom_range(1, 6));
			end
		endcase
		return c;
	endfunction

	function automatic ppdm_pkg::in_item_t random_tick();
		ppdm_pkg::in_item_t t;
		int                 jitter;
		bit                 opening;
		opening = 1'b0;
		if ($urandom_range(0, 99) < 6) begin
			t.measured_position = $urandom;
			t.measured_speed = $urandom;
			t.reference_position = $urandom;
			t.reference_speed = $urandom;
			t.target_position = $urandom;
			t.external_mode = 1'($urandom_range(0, 1));
			t.trajectory_done = 1'($urandom_range(0, 1));
			t.new_command = 1'($urandom_range(0, 1));
			t.speed_loop_ok = 1'($urandom_range(0, 1));
			return t;
		end
		if (seq_left == 0) begin
			seq_left = $urandom_range(3, 40);
			seq_ext = 1'($urandom_range(0, 1));
			seq_target = ($urandom_range(0, 3) == 0) ? int'($urandom)
				: $urandom_range(0, 2000) - 1000;
			seq_dist = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000)
				: $urandom_range(0, 60);
			// some moves run away from the reference and should trip the error monitor
			seq_runaway = ($urandom_range(0, 5) == 0);
			seq_push = $urandom_range(0, 1) ? $urandom_range(500, 5000000)
				: -$urandom_range(500, 5000000);
			opening = 1'b1;
		end
		seq_left--;
		jitter = $urandom_range(0, 4) - 2;
		t.target_position = seq_target;
		t.measured_position = seq_target - seq_dist + jitter;
		if (seq_ext) t.reference_position = seq_target;
		else t.reference_position = t.measured_position + $urandom_range(0, 40) - 20;
		if (seq_runaway) t.reference_position = t.reference_position + seq_push;
		if ($urandom_range(0, 19) == 0) t.reference_position = $urandom;
		t.measured_speed = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300) - 150;
		t.reference_speed = ($urandom_range(0, 7) == 0) ? $urandom
			: $urandom_range(0, 20000) - 10000;
		t.external_mode = ($urandom_range(0, 19) == 0) ? !seq_ext : seq_ext;
		t.trajectory_done = (seq_left < 12) ? ($urandom_range(0, 9) != 0)
			: ($urandom_range(0, 3) == 0);
		t.new_command = opening ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 99) == 0);
		t.speed_loop_ok = ($urandom_range(0, 49) != 0);
		seq_dist = seq_dist * 3 / 4;
		return t;
	endfunction

	// called just after a rising edge; returns at the edge that takes the beat
	task automatic offer(input ppdm_pkg::in_item_t t);
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 30);
			end
			burst_left--;
		end
		measured_position <= t.measured_position;
		measured_speed <= t.measured_speed;
		reference_position <= t.reference_position;
		reference_speed <= t.reference_speed;
		target_position <= t.target_position;
		external_mode <= t.external_mode;
		trajectory_done <= t.trajectory_done;
		new_command <= t.new_command;
		speed_loop_ok <= t.speed_loop_ok;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_config(input ppdm_pkg::cfg_t c);
		logic [2:0]  regs [8];
		logic [30:0] vals [8];
		regs = '{ppdm_pkg::REG_POSITION_GAIN, ppdm_pkg::REG_DAMPING_GAIN,
			ppdm_pkg::REG_TRACKING_SPEED_LIMIT, ppdm_pkg::REG_SETTLE_TOLERANCE,
			ppdm_pkg::REG_SETTLE_SPEED_LIMIT, ppdm_pkg::REG_SETTLE_TICKS,
			ppdm_pkg::REG_ERROR_MARGIN, ppdm_pkg::REG_ERROR_TIMEOUT_TICKS};
		vals = '{31'(c.position_gain), 31'(c.damping_gain), c.tracking_speed_limit,
			c.settle_tolerance, c.settle_speed_limit, 31'(c.settle_ticks),
			c.error_margin, 31'(c.error_timeout_ticks)};
		foreach (regs[i]) begin
			cfg_write <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	// let every beat in flight come out, then a little more than the pipeline depth
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (12) @(posedge clk);
	endtask

	// receiver: one long hold while the first ticks arrive, then its own stall pattern
	initial begin
		int mode, len;
		wait (arst_n);
		do @(posedge clk); while (!in_valid);
		repeat (60) begin
			out_stall <= 1'b1;
			@(posedge clk);
		end
		forever begin
			mode = $urandom_range(0, 7);
			len = $urandom_range(20, 120);
			repeat (len) begin
				case (mode)
					0, 1, 2: out_stall <= 1'b0;
					3, 4:    out_stall <= ($urandom_range(0, 99) < 30);
					5, 6:    out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= 1'b1;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		ppdm_pkg::in_item_t steps[$];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(pick_config(SETUP_DIRECTED));
		gaps_on = 1'b0;
		steps.push_back(make_tick(100, 0, 200, 0, 200, 1, 0, 0, 1));     // idle, not running
		steps.push_back(make_tick(0, 0, 1000, 0, 1000, 1, 0, 1, 1));     // start in step mode
		steps.push_back(make_tick(1000, 0, 0, 0, 1000, 1, 0, 0, 1));
		steps.push_back(make_tick(0, 100000, 10, 0, 1000, 1, 0, 0, 1));  // damping flips sign
		steps.push_back(make_tick(998, 0, 1000, 0, 1000, 1, 1, 0, 1));
		steps.push_back(make_tick(0, 0, 0, ppdm_pkg::S32_HIGH, 0, 0, 0, 0, 1));  // clamp high
		steps.push_back(make_tick(0, 0, 0, ppdm_pkg::S32_LOW, 0, 0, 0, 0, 1));   // clamp low
		steps.push_back(make_tick(ppdm_pkg::S32_LOW, 0, ppdm_pkg::S32_HIGH, 0, 0, 0, 0, 0, 1));
		steps.push_back(make_tick(ppdm_pkg::S32_HIGH, 0, ppdm_pkg::S32_LOW, 0, 0, 0, 0, 0, 1));
		steps.push_back(make_tick(5, 0, 6, 0, 6, 0, 1, 0, 1));           // stopped after fault
		steps.push_back(make_tick(500, 0, 500, 0, 500, 0, 1, 1, 1));
		steps.push_back(make_tick(501, 50, 500, 0, 500, 0, 1, 0, 1));
		steps.push_back(make_tick(500, ppdm_pkg::S32_LOW, 500, 0, 500, 0, 1, 0, 1));
		steps.push_back(make_tick(500, ppdm_pkg::S32_HIGH, 500, 0, 500, 0, 0, 0, 1));
		steps.push_back(make_tick(500, 0, 500, 0, 500, 0, 1, 0, 0));     // speed loop lost
		steps.push_back(make_tick(0, 0, 0, 0, 0, 1, 0, 1, 0));           // start with loop lost
		steps.push_back(make_tick(ppdm_pkg::S32_HIGH, 0, ppdm_pkg::S32_HIGH, 0,
			ppdm_pkg::S32_LOW, 1, 0, 1, 1));
		repeat (4) steps.push_back(make_tick(ppdm_pkg::S32_HIGH - 3, -777, ppdm_pkg::S32_HIGH,
			0, ppdm_pkg::S32_LOW, 1, 0, 0, 1));
		steps.push_back(make_tick(-1, -1, -1, -1, -1, 0, 1, 0, 1));
		foreach (steps[i]) offer(steps[i]);
		drain();

		// zero limit, margin and tick counts
		write_config(pick_config(SETUP_ZERO));
		steps.delete();
		steps.push_back(make_tick(0, 0, 50, 0, 0, 0, 1, 1, 1));
		steps.push_back(make_tick(7, 0, 7, 0, 7, 1, 0, 1, 1));
		repeat (4) steps.push_back(make_tick(7, 3, 9, 0, 7, 1, 0, 0, 1));
		foreach (steps[i]) offer(steps[i]);
		drain();

		gaps_on = 1'b1;
		for (int p = 0; p < 8; p++) begin
			write_config(pick_config(p == 0 ? SETUP_MAX : (p == 1 ? SETUP_MIN : SETUP_RANDOM)));
			seq_left = 0;
			repeat (250) offer(random_tick());
			drain();
		end

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- position_pd_loop_with_monitor.f -----
rtl/core/ppdm_pkg.sv
rtl/core/ppdm_cfg_regs.sv
rtl/core/ppdm_front.sv
rtl/core/ppdm_monitor.sv
rtl/core/ppdm_damp_div.sv
rtl/core/ppdm_cmd.sv
rtl/core/position_pd_loop_with_monitor.sv
test/ppdm_tick_checker.sv
test/position_pd_loop_with_monitor_tb.sv
